// File: rtl/lmtp_pkg.sv
// Shared types, constants and the LFSR step for the memory test pattern engine.
// No dependencies; used by lmtp_engine and lfsr_memory_test_pattern.
`timescale 1ns / 1ps
`default_nettype none

package lmtp_pkg;

    // Command codes carried in the input item
    localparam logic [1:0] CmdRestart = 2'd0;
    localparam logic [1:0] CmdFill    = 2'd1;
    localparam logic [1:0] CmdCheck   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CfgSeed   = 2'd0;
    localparam logic [1:0] CfgLength = 2'd1;
    localparam logic [1:0] CfgBase   = 2'd2;

    localparam logic [31:0] LfsrPoly  = 32'hA000_0001;
    localparam logic [31:0] SeedReset = 32'hFFFF_FFFF;
    localparam logic [15:0] LengthReset = 16'd4096;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] read_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pattern_byte;
        logic [31:0] byte_address;
        logic        mismatch;
        logic        failed;
        logic [31:0] fail_address;
        logic        done_res;
    } t_out_item;

    // One right shift of the Galois LFSR
    function automatic logic [31:0] lfsr_advance(input logic [31:0] s);
        lfsr_advance = {1'b0, s[31:1]} ^ (s[0] ? LfsrPoly : 32'd0);
    endfunction

endpackage

`default_nettype wire

// File: rtl/lmtp_engine.sv
// Pattern engine state (LFSR, byte offset, failure record) and the result logic.
// Depends on lmtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmtp_engine #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_fire,
    input  lmtp_pkg::t_in_item        i_item,
    input  wire  [31:0]               i_seed,
    input  wire  [LENGTH_BITS-1:0]    i_test_length,
    input  wire  [31:0]               i_base_address,
    output lmtp_pkg::t_out_item       o_result
);

    logic [31:0]            r_lfsr;
    logic [LENGTH_BITS-1:0] r_offset;
    logic                   r_fail;
    logic [31:0]            r_fail_addr;
    logic                   r_finished;

    logic [31:0]            n_lfsr;
    logic [LENGTH_BITS-1:0] n_offset;
    logic                   n_fail;
    logic [31:0]            n_fail_addr;
    logic                   n_finished;

    logic                   run_done;
    logic                   is_step;
    logic                   is_restart;
    logic [31:0]            lfsr_step;
    logic [31:0]            step_addr;
    logic [LENGTH_BITS-1:0] offset_inc;
    logic                   step_mis;
    logic                   step_fin;

    always_comb begin
        run_done   = r_finished || (r_offset >= i_test_length);
        is_restart = (i_item.cmd == lmtp_pkg::CmdRestart);
        is_step    = ((i_item.cmd == lmtp_pkg::CmdFill) || (i_item.cmd == lmtp_pkg::CmdCheck))
                     && !run_done;
        lfsr_step  = lmtp_pkg::lfsr_advance(r_lfsr);
        step_addr  = i_base_address + 32'(r_offset);
        offset_inc = r_offset + LENGTH_BITS'(1);
        step_mis   = (i_item.cmd == lmtp_pkg::CmdCheck) && (i_item.read_byte != lfsr_step[7:0]);
        step_fin   = r_finished || step_mis || (offset_inc >= i_test_length);

        n_lfsr      = r_lfsr;
        n_offset    = r_offset;
        n_fail      = r_fail;
        n_fail_addr = r_fail_addr;
        n_finished  = r_finished;

        o_result.pattern_byte = 8'd0;
        o_result.byte_address = 32'd0;
        o_result.mismatch     = 1'b0;
        o_result.failed       = r_fail;
        o_result.fail_address = r_fail_addr;
        o_result.done_res     = run_done;

        if (is_restart) begin
            n_lfsr      = i_seed;
            n_offset    = '0;
            n_fail      = 1'b0;
            n_fail_addr = 32'd0;
            n_finished  = 1'b0;
            o_result.byte_address = i_base_address;
            o_result.failed       = 1'b0;
            o_result.fail_address = 32'd0;
            o_result.done_res     = (i_test_length == '0);
        end else if (is_step) begin
            n_lfsr     = lfsr_step;
            n_offset   = offset_inc;
            n_finished = step_fin;
            if (step_mis) begin
                n_fail      = 1'b1;
                n_fail_addr = step_addr;
            end
            o_result.pattern_byte = lfsr_step[7:0];
            o_result.byte_address = step_addr;
            o_result.mismatch     = step_mis;
            o_result.failed       = n_fail;
            o_result.fail_address = n_fail_addr;
            o_result.done_res     = step_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= lmtp_pkg::SeedReset;
            r_offset    <= '0;
            r_fail      <= 1'b0;
            r_fail_addr <= 32'd0;
            r_finished  <= 1'b0;
        end else if (i_fire) begin
            r_lfsr      <= n_lfsr;
            r_offset    <= n_offset;
            r_fail      <= n_fail;
            r_fail_addr <= n_fail_addr;
            r_finished  <= n_finished;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfsr_memory_test_pattern.sv
// Items pass the input register, then the result register. One transfer per cycle
// while o_in_stall is low; the LFSR step, offset add and compare are combinational.
// A skid register behind the result register holds one result while the output stalls.
// Reset (synchronous, active low): LFSR all ones, offset and failure record cleared,
// seed 0xFFFFFFFF, length 4096, base 0; no item in flight.
// Depends on lmtp_pkg and lmtp_engine.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_memory_test_pattern #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  lmtp_pkg::t_in_item   i_in_item,
    // output channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output lmtp_pkg::t_out_item  o_out_item,
    // configuration writes
    input  wire                  i_cfg_wr_en,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);

    // The length register keeps only the bits that both its 16-bit field and the
    // offset counter can hold.
    localparam int LenCfgW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

    // Configuration registers
    logic [31:0]        r_seed;
    logic [LenCfgW-1:0] r_test_length;
    logic [31:0]        r_base_address;

    // Input register
    logic               r_in_valid;
    lmtp_pkg::t_in_item r_in_item;

    // Result register and skid register
    logic                r_out_valid;
    lmtp_pkg::t_out_item r_out_item;
    logic                r_skid_valid;
    lmtp_pkg::t_out_item r_skid_item;

    logic                in_xfer;
    logic                out_xfer;
    logic                fire;
    logic                out_free;
    lmtp_pkg::t_out_item result;

    // Hold the input only when an item waits in the input register and the
    // skid register is occupied.
    assign o_in_stall  = r_in_valid && r_skid_valid;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign out_free    = out_xfer || !r_out_valid;
    // Evaluate the held item whenever there is somewhere to put its result.
    assign fire        = r_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed         <= lmtp_pkg::SeedReset;
            r_test_length  <= lmtp_pkg::LengthReset[LenCfgW-1:0];
            r_base_address <= 32'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lmtp_pkg::CfgSeed:   r_seed         <= i_cfg_data;
                lmtp_pkg::CfgLength: r_test_length  <= i_cfg_data[LenCfgW-1:0];
                lmtp_pkg::CfgBase:   r_base_address <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load on transfer, drop once evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    lmtp_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in_item),
        .i_seed         (r_seed),
        .i_test_length  (LENGTH_BITS'(r_test_length)),
        .i_base_address (r_base_address),
        .o_result       (result)
    );

    // Result and skid registers: the skid drains first so order is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= fire;
            end
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (fire) begin
                r_out_item <= result;
            end
        end else if (fire) begin
            r_skid_item <= result;
        end
    end

    // The skid register is only ever filled behind a held result.
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register occupied while result register empty");

    // A mismatch ends the run and records its own address.
    a_mismatch_latched : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.mismatch) |->
            (o_out_item.failed && o_out_item.done_res
             && (o_out_item.fail_address == o_out_item.byte_address)))
        else $error("mismatch result without latched failure");

    // A recorded failure always leaves the engine done.
    a_failed_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.failed) |-> o_out_item.done_res)
        else $error("failed flag set while engine not done");

endmodule

`default_nettype wire
